/* hw/rtl/pfla_pkg.sv */
// Shared types, constants and the control store for the page free-list allocator.
// Depends on nothing; every other file of the allocator but pfla_ram imports it.
`default_nettype none

package pfla_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PAGE_W    = 10;
    localparam int ADDR_W    = $clog2(MAX_PAGES);
    localparam int BUMP_W    = $clog2(MAX_PAGES + 1);
    localparam int UPC_W     = 4;

    localparam logic [BUMP_W-1:0] MAX_PAGES_B = BUMP_W'(MAX_PAGES);

    typedef logic [PAGE_W-1:0] t_page;
    typedef logic [BUMP_W-1:0] t_bump;
    typedef logic [UPC_W-1:0]  t_upc;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_INVALID      = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_FULL         = 2'd3
    } t_status;

    typedef struct packed {
        t_op   op;
        t_page page;
    } t_req;

    typedef struct packed {
        t_page   granted_page;
        t_status status;
    } t_rsp;

    // Datapath actions, one per microinstruction.
    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_RD_HEAD,
        A_POP,
        A_BUMP,
        A_CUR_INIT,
        A_RD_CUR,
        A_STEP_CUR,
        A_LINK,
        A_RESULT,
        A_EMIT
    } t_act;

    // Branch conditions tested by the sequencer.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_OP_FREE,
        C_HEAD_ZERO,
        C_BUMP_FULL,
        C_PG_INVALID,
        C_CUR_END,
        C_CUR_MATCH,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_act    act;
        t_cond   cond;
        t_upc    jmp;
        t_status st;
    } t_uword;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic op_free;
        logic head_zero;
        logic bump_full;
        logic pg_invalid;
        logic cur_end;
        logic cur_match;
        logic out_busy;
    } t_flags;

    localparam t_upc U_WAIT     = 4'd0;
    localparam t_upc U_DISPATCH = 4'd1;
    localparam t_upc U_ALLOC    = 4'd2;
    localparam t_upc U_POP      = 4'd3;
    localparam t_upc U_BUMPCHK  = 4'd4;
    localparam t_upc U_BUMP     = 4'd5;
    localparam t_upc U_FREE     = 4'd6;
    localparam t_upc U_WALK     = 4'd7;
    localparam t_upc U_CHECK    = 4'd8;
    localparam t_upc U_LOOP     = 4'd9;
    localparam t_upc U_LINK     = 4'd10;
    localparam t_upc U_FULL     = 4'd11;
    localparam t_upc U_INVALID  = 4'd12;
    localparam t_upc U_DUP      = 4'd13;
    localparam t_upc U_EMIT     = 4'd15;

    // Control store. A taken condition loads jmp, otherwise the step counter
    // advances; the emit step sits last so that falling through wraps to wait.
    function automatic t_uword ucode(t_upc a);
        t_uword w;
        unique case (a)
            U_WAIT:     w = '{A_ACCEPT,   C_NO_INPUT,   U_WAIT,    ST_OK};
            U_DISPATCH: w = '{A_NONE,     C_OP_FREE,    U_FREE,    ST_OK};
            U_ALLOC:    w = '{A_RD_HEAD,  C_HEAD_ZERO,  U_BUMPCHK, ST_OK};
            U_POP:      w = '{A_POP,      C_ALWAYS,     U_EMIT,    ST_OK};
            U_BUMPCHK:  w = '{A_NONE,     C_BUMP_FULL,  U_FULL,    ST_OK};
            U_BUMP:     w = '{A_BUMP,     C_ALWAYS,     U_EMIT,    ST_OK};
            U_FREE:     w = '{A_CUR_INIT, C_PG_INVALID, U_INVALID, ST_OK};
            U_WALK:     w = '{A_RD_CUR,   C_CUR_END,    U_LINK,    ST_OK};
            U_CHECK:    w = '{A_STEP_CUR, C_CUR_MATCH,  U_DUP,     ST_OK};
            U_LOOP:     w = '{A_NONE,     C_ALWAYS,     U_WALK,    ST_OK};
            U_LINK:     w = '{A_LINK,     C_ALWAYS,     U_EMIT,    ST_OK};
            U_FULL:     w = '{A_RESULT,   C_ALWAYS,     U_EMIT,    ST_FULL};
            U_INVALID:  w = '{A_RESULT,   C_ALWAYS,     U_EMIT,    ST_INVALID};
            U_DUP:      w = '{A_RESULT,   C_ALWAYS,     U_EMIT,    ST_ALREADY_FREE};
            U_EMIT:     w = '{A_EMIT,     C_OUT_BUSY,   U_EMIT,    ST_OK};
            default:    w = '{A_NONE,     C_ALWAYS,     U_WAIT,    ST_OK};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfla_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module pfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/pfla_useq.sv */
// Microprogram sequencer: step counter, control store lookup and branch logic.
// Depends on pfla_pkg for the control word, flags and the control store.
`default_nettype none

module pfla_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pfla_pkg::t_flags i_flags,
    output pfla_pkg::t_upc       o_upc,
    output pfla_pkg::t_uword     o_uword
);
    import pfla_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   taken;

    assign uw = ucode(r_upc);

    always_comb begin
        unique case (uw.cond)
            C_NEVER:      taken = 1'b0;
            C_ALWAYS:     taken = 1'b1;
            C_NO_INPUT:   taken = !i_flags.in_valid;
            C_OP_FREE:    taken = i_flags.op_free;
            C_HEAD_ZERO:  taken = i_flags.head_zero;
            C_BUMP_FULL:  taken = i_flags.bump_full;
            C_PG_INVALID: taken = i_flags.pg_invalid;
            C_CUR_END:    taken = i_flags.cur_end;
            C_CUR_MATCH:  taken = i_flags.cur_match;
            C_OUT_BUSY:   taken = i_flags.out_busy;
            default:      taken = 1'b0;
        endcase
        n_upc = taken ? uw.jmp : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_upc   = r_upc;
    assign o_uword = uw;

endmodule

`default_nettype wire

/* hw/rtl/pfla_dpath.sv */
// Allocator datapath: list head, bump pointer, walk cursor, result registers
// and the next-link store. Depends on pfla_pkg and pfla_ram.
`default_nettype none

module pfla_dpath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pfla_pkg::t_uword i_uword,
    input  wire logic             i_in_valid,
    input  wire pfla_pkg::t_req   i_in,
    input  wire logic             i_out_busy,
    output pfla_pkg::t_flags      o_flags,
    output pfla_pkg::t_rsp        o_rsp
);
    import pfla_pkg::*;

    t_page   r_head;
    t_bump   r_bump;
    t_op     r_op;
    t_page   r_pg;
    t_page   r_cur;
    t_bump   r_hops;
    t_page   r_granted;
    t_status r_status;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    t_page             ram_rdata;

    assign ram_we    = (i_uword.act == A_LINK);
    assign ram_raddr = (i_uword.act == A_RD_HEAD) ? ADDR_W'(r_head) : ADDR_W'(r_cur);

    pfla_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(r_pg)),
        .i_wdata (r_head),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_flags.in_valid   = i_in_valid;
        o_flags.op_free    = (r_op == OP_FREE);
        o_flags.head_zero  = (r_head == '0);
        o_flags.bump_full  = (r_bump >= MAX_PAGES_B);
        o_flags.pg_invalid = (r_pg == '0) || (BUMP_W'(r_pg) >= r_bump)
                             || (BUMP_W'(r_pg) >= MAX_PAGES_B);
        o_flags.cur_end    = (r_cur == '0) || (BUMP_W'(r_cur) >= MAX_PAGES_B)
                             || (r_hops >= MAX_PAGES_B);
        o_flags.cur_match  = (r_cur == r_pg);
        o_flags.out_busy   = i_out_busy;
    end

    // Control state: list head and bump pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_bump <= BUMP_W'(1);
        end else begin
            unique case (i_uword.act)
                A_POP:   r_head <= ram_rdata;
                A_BUMP:  r_bump <= r_bump + 1'b1;
                A_LINK:  r_head <= r_pg;
                default: ;
            endcase
        end
    end

    // Request, walk cursor and result registers.
    always_ff @(posedge i_clk) begin
        unique case (i_uword.act)
            A_ACCEPT: begin
                if (i_in_valid) begin
                    r_op <= i_in.op;
                    r_pg <= i_in.page;
                end
            end
            A_POP: begin
                r_granted <= r_head;
                r_status  <= i_uword.st;
            end
            A_BUMP: begin
                r_granted <= PAGE_W'(r_bump);
                r_status  <= i_uword.st;
            end
            A_CUR_INIT: begin
                r_cur  <= r_head;
                r_hops <= '0;
            end
            A_STEP_CUR: begin
                r_cur  <= ram_rdata;
                r_hops <= r_hops + 1'b1;
            end
            A_LINK, A_RESULT: begin
                r_granted <= '0;
                r_status  <= i_uword.st;
            end
            default: ;
        endcase
    end

    assign o_rsp.granted_page = r_granted;
    assign o_rsp.status       = r_status;

endmodule

`default_nettype wire

/* hw/rtl/page_free_list_allocator.sv */
// Page allocator with a LIFO free list, run by a microprogrammed sequencer.
//
// Requests arrive on i_in (op, page) with i_in_valid/o_in_stall; a request
// transfers at a clock edge with valid high and stall low. Each request
// gives exactly one response on o_out (granted_page, status) with
// o_out_valid/i_out_stall, transferred the same way.
// An allocate pops the list head if the list is not empty, else takes the bump
// pointer or reports full; a free reports invalid for a bad page, else walks the
// free list and either links the page at the head or reports a double free on
// finding it. The wait step comes before the next request can transfer. The
// list walk, one link-store read per hop, sets the free latency; one request
// is in the sequencer at a time.
// The response sits in an output register, so the next request can transfer
// while the last response still waits. If the receiver stalls and the output
// register is still full when a new response is ready, the sequencer holds
// on its emit step and does not take further requests.
// Reset (synchronous, active low) empties the free list and sets the bump
// pointer to page 1; the link store needs no clearing and a request can
// transfer in the first cycle after reset.
// Depends on pfla_pkg, pfla_useq, pfla_dpath and pfla_ram.
`default_nettype none

module page_free_list_allocator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire pfla_pkg::t_req i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output pfla_pkg::t_rsp      o_out
);
    import pfla_pkg::*;

    t_flags flags;
    t_uword uword;
    t_upc   upc;
    t_rsp   rsp;
    logic   out_busy;
    logic   out_load;
    logic   r_out_valid;
    t_rsp   r_out;

    pfla_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_upc   (upc),
        .o_uword (uword)
    );

    pfla_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uword    (uword),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_out_busy (out_busy),
        .o_flags    (flags),
        .o_rsp      (rsp)
    );

    assign o_in_stall = (upc != U_WAIT);
    assign out_busy   = r_out_valid && i_out_stall;
    assign out_load   = (uword.act == A_EMIT) && !out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The sequencer only leaves the wait step on a request transfer.
    a_dispatch_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upc == U_DISPATCH) |-> $past(i_in_valid && !o_in_stall))
        else $error("dispatch step reached without a request transfer");

    // A loaded response is presented in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("response loaded but not presented");

    // A response with an error status carries page zero.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> (o_out.granted_page == '0))
        else $error("nonzero page with an error status");

endmodule

`default_nettype wire

/* sim/pfla_checker.sv */
// Response checker for the page free-list allocator: predicts each response from the
// requests that transfer and compares it with what leaves the block.
// Depends on pfla_pkg for the request and response types.
`default_nettype none

module pfla_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire pfla_pkg::t_req   i_in,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire pfla_pkg::t_rsp   i_out,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfla_pkg::*;

    // Shadow copy of the allocator state.
    t_page head_page;
    t_bump bump_page;
    t_page link_of [MAX_PAGES];

    t_rsp  pending_responses [$];
    int    mismatches = 0;

    function automatic t_rsp predict_response(t_req req);
        t_rsp  rsp;
        t_page cur;
        int    hops;
        logic  listed;
        rsp.granted_page = '0;
        rsp.status       = ST_OK;
        if (req.op == OP_ALLOC) begin
            if (head_page != '0) begin
                rsp.granted_page = head_page;
                head_page        = link_of[head_page];
            end else if (bump_page >= MAX_PAGES_B) begin
                rsp.status = ST_FULL;
            end else begin
                rsp.granted_page = t_page'(bump_page);
                bump_page        = bump_page + 1'b1;
            end
        end else if (req.page == '0 || t_bump'(req.page) >= bump_page) begin
            rsp.status = ST_INVALID;
        end else begin
            // Walk the free list looking for the page; the hop bound only
            // matters if the list were ever corrupted.
            listed = 1'b0;
            cur    = head_page;
            hops   = 0;
            while (cur != '0 && hops < MAX_PAGES && !listed) begin
                listed = (cur == req.page);
                cur    = link_of[cur];
                hops++;
            end
            if (listed) begin
                rsp.status = ST_ALREADY_FREE;
            end else begin
                link_of[req.page] = head_page;
                head_page         = req.page;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            head_page = '0;
            bump_page = t_bump'(1);
            foreach (link_of[k]) link_of[k] = '0;
            pending_responses.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_responses.size() == 0) begin
                    $error("response with none pending: granted_page %0d, status %0d",
                           i_out.granted_page, i_out.status);
                    mismatches++;
                end else begin
                    want = pending_responses.pop_front();
                    if (i_out.granted_page !== want.granted_page) begin
                        $error("granted_page mismatch: expected %0d, actual %0d",
                               want.granted_page, i_out.granted_page);
                        mismatches++;
                    end
                    if (i_out.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_out.status);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_responses.push_back(predict_response(i_in));
            end
        end
        o_pending    <= pending_responses.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

/* sim/page_free_list_allocator_tb.sv */
// Top of the page free-list allocator testbench: clock, reset, request stimulus
// and receiver stalls, with pfla_checker doing the prediction and comparison.
// Depends on pfla_pkg, pfla_checker and the allocator RTL.
`default_nettype none

module page_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfla_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    t_req  in_req;
    logic  out_valid;
    logic  out_stall = 1'b0;
    t_rsp  out_rsp;
    int    fail_count;
    int    pending;

    int    send_idle_pct = 0;
    int    stall_pct     = 0;
    t_page held_pages [$];
    t_page recent_frees [$];

    page_free_list_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp)
    );

    pfla_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Pages granted so far are the pool that well-formed frees draw from.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (out_rsp.status == ST_OK && out_rsp.granted_page != '0) begin
                held_pages.push_back(out_rsp.granted_page);
            end
        end
    end

    task automatic send_request(t_req req);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_req   <= req;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Allocates slightly outnumber frees; frees are mostly of pages actually held, with
    // some double frees, frees of the reserved page and frees of arbitrary page numbers.
    task automatic send_random();
        t_req req;
        int   pick;
        int   idx;
        req.op   = ($urandom_range(99) < 55) ? OP_ALLOC : OP_FREE;
        req.page = t_page'($urandom_range(MAX_PAGES - 1));
        if (req.op == OP_FREE) begin
            pick = $urandom_range(99);
            if (pick < 70 && held_pages.size() > 0) begin
                idx      = $urandom_range(held_pages.size() - 1);
                req.page = held_pages[idx];
                held_pages.delete(idx);
                recent_frees.push_back(req.page);
                if (recent_frees.size() > 8) void'(recent_frees.pop_front());
            end else if (pick < 82 && recent_frees.size() > 0) begin
                req.page = recent_frees[$urandom_range(recent_frees.size() - 1)];
            end else if (pick < 88) begin
                req.page = '0;
            end
        end
        send_request(req);
    endtask

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_req   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bump grants, invalid frees at both ends of the page range,
        // double frees at the head and deeper in the list, pops from the list.
        send_request('{OP_ALLOC, t_page'($urandom)});
        send_request('{OP_ALLOC, t_page'($urandom)});
        send_request('{OP_ALLOC, t_page'($urandom)});
        send_request('{OP_FREE,  t_page'(0)});
        send_request('{OP_FREE,  t_page'(4)});
        send_request('{OP_FREE,  t_page'(MAX_PAGES - 1)});
        send_request('{OP_FREE,  t_page'(2)});
        send_request('{OP_FREE,  t_page'(2)});
        send_request('{OP_FREE,  t_page'(1)});
        send_request('{OP_FREE,  t_page'(2)});
        send_request('{OP_FREE,  t_page'(3)});
        send_request('{OP_FREE,  t_page'(1)});
        send_request('{OP_ALLOC, t_page'($urandom)});
        send_request('{OP_ALLOC, t_page'($urandom)});
        send_request('{OP_ALLOC, t_page'($urandom)});
        send_request('{OP_ALLOC, t_page'($urandom)});

        // Random traffic under each idling mix.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 47; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 47; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            repeat (140) send_random();
        end

        // A burst of allocates that grows the pool, then mixed traffic again.
        repeat (80) send_request('{OP_ALLOC, t_page'($urandom)});
        repeat (40) send_random();
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (30) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/pfla_pkg.sv
hw/rtl/pfla_ram.sv
hw/rtl/pfla_useq.sv
hw/rtl/pfla_dpath.sv
hw/rtl/page_free_list_allocator.sv
sim/pfla_checker.sv
sim/page_free_list_allocator_tb.sv
